FILE: design/dpnbm_pkg.sv
`default_nettype none

package dpnbm_pkg;

  localparam int unsigned WIN_LEN         = 30;
  localparam int unsigned PAT_LEN         = 29;
  localparam int unsigned PATTERNS_DEF    = 16;
  localparam int unsigned SLOT_STRIDE_DEF = 32;

  localparam logic [7:0] CHAR_A     = 8'd65;
  localparam logic [7:0] CHAR_G     = 8'd71;
  localparam logic [7:0] CHAR_C     = 8'd67;
  localparam logic [7:0] CHAR_T     = 8'd84;
  localparam logic [7:0] CHAR_SPACE = 8'd32;

  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_G = 2'd1;
  localparam logic [1:0] CODE_C = 2'd2;
  localparam logic [1:0] CODE_T = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_PUSH   = 2'd1,
    OP_FINISH = 2'd2
  } op_e;

  typedef struct packed {
    logic       ok;
    logic [1:0] code;
  } base_t;

  function automatic base_t encode_base(logic [7:0] sym);
    base_t b;
    b.ok   = 1'b1;
    b.code = CODE_A;
    case (sym)
      CHAR_A:  b.code = CODE_A;
      CHAR_G:  b.code = CODE_G;
      CHAR_C:  b.code = CODE_C;
      CHAR_T:  b.code = CODE_T;
      default: b.ok = 1'b0;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] decode_base(logic [1:0] code);
    logic [7:0] c;
    case (code)
      CODE_A:  c = CHAR_A;
      CODE_G:  c = CHAR_G;
      CODE_C:  c = CHAR_C;
      default: c = CHAR_T;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: design/dpnbm_scan.sv
`default_nettype none

module dpnbm_scan
  import dpnbm_pkg::*;
#(
  parameter int unsigned PATTERNS    = PATTERNS_DEF,
  parameter int unsigned SLOT_STRIDE = SLOT_STRIDE_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       fire_i,
  input  wire logic [1:0] op_i,
  input  wire logic [7:0] sym_i,
  input  wire logic [8:0] slot_i,
  output logic            found_o [PATTERNS],
  output logic [1:0]      base_o  [PATTERNS]
);

  logic [1:0] win_base_q  [WIN_LEN];
  logic       win_valid_q [WIN_LEN];
  logic [1:0] pat_q       [PATTERNS][PAT_LEN];
  logic       found_q     [PATTERNS];
  logic [1:0] mbase_q     [PATTERNS];
  logic       hit         [PATTERNS];
  base_t      enc;
  logic       all_valid;

  assign enc = encode_base(sym_i);

  always_comb begin
    all_valid = enc.ok;
    for (int k = 0; k < PAT_LEN; k++) begin
      all_valid = all_valid & win_valid_q[k];
    end
  end

  // after the shift, window entry 29-p (old entry 28-p) meets pattern position p
  for (genvar j = 0; j < PATTERNS; j++) begin : g_cmp
    always_comb begin
      hit[j] = all_valid;
      for (int p = 0; p < PAT_LEN; p++) begin
        if (win_base_q[PAT_LEN-1-p] != pat_q[j][p]) hit[j] = 1'b0;
      end
    end
  end

  // pattern store: one register per compared position, no reset
  for (genvar j = 0; j < PATTERNS; j++) begin : g_pat
    for (genvar p = 0; p < PAT_LEN; p++) begin : g_pos
      always_ff @(posedge clk_i) begin
        if (fire_i && op_i == OP_LOAD &&
            32'(slot_i) == 32'(j * SLOT_STRIDE + p)) begin
          pat_q[j][p] <= enc.code;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WIN_LEN; k++) begin
        win_base_q[k]  <= CODE_A;
        win_valid_q[k] <= 1'b0;
      end
      for (int j = 0; j < PATTERNS; j++) begin
        found_q[j] <= 1'b0;
        mbase_q[j] <= CODE_A;
      end
    end else if (fire_i) begin
      case (op_i)
        OP_PUSH: begin
          for (int k = WIN_LEN - 1; k > 0; k--) begin
            win_base_q[k]  <= win_base_q[k-1];
            win_valid_q[k] <= win_valid_q[k-1];
          end
          win_base_q[0]  <= enc.code;
          win_valid_q[0] <= enc.ok;
          for (int j = 0; j < PATTERNS; j++) begin
            if (hit[j]) begin
              found_q[j] <= 1'b1;
              mbase_q[j] <= enc.code;
            end
          end
        end
        OP_FINISH: begin
          for (int k = 0; k < WIN_LEN; k++) begin
            win_base_q[k]  <= CODE_A;
            win_valid_q[k] <= 1'b0;
          end
          for (int j = 0; j < PATTERNS; j++) begin
            found_q[j] <= 1'b0;
            mbase_q[j] <= CODE_A;
          end
        end
        default: ;
      endcase
    end
  end

  assign found_o = found_q;
  assign base_o  = mbase_q;

endmodule

`default_nettype wire

FILE: design/dpnbm_emit.sv
`default_nettype none

module dpnbm_emit
  import dpnbm_pkg::*;
#(
  parameter int unsigned PATTERNS = PATTERNS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       load_i,
  input  wire logic       found_i [PATTERNS],
  input  wire logic [1:0] base_i  [PATTERNS],
  output logic            busy_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      result_char_o,
  output logic [3:0]      pattern_index_o,
  output logic            last_o
);

  localparam int unsigned IDX_W = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;

  logic             busy_q;
  logic [IDX_W-1:0] idx_q;
  logic             found_q [PATTERNS];
  logic [1:0]       base_q  [PATTERNS];
  logic             last;
  logic             take;
  logic [IDX_W+3:0] idx_ext;

  assign last    = (idx_q == IDX_W'(PATTERNS - 1));
  assign take    = busy_q && out_ready_i;
  assign idx_ext = {4'b0000, idx_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (take) begin
      if (last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // snapshot shifts toward entry 0, which always holds the current result
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      found_q <= found_i;
      base_q  <= base_i;
    end else if (take) begin
      for (int j = 0; j < PATTERNS - 1; j++) begin
        found_q[j] <= found_q[j+1];
        base_q[j]  <= base_q[j+1];
      end
    end
  end

  assign busy_o          = busy_q;
  assign out_valid_o     = busy_q;
  assign result_char_o   = found_q[0] ? decode_base(base_q[0]) : CHAR_SPACE;
  assign pattern_index_o = idx_ext[3:0];
  assign last_o          = last;

endmodule

`default_nettype wire

FILE: design/dna_prefix_next_base_match.sv
// DNA prefix match: reports the base that follows each stored 29-base pattern.
// Input channel (in_valid_i/in_ready_o) carries operation, symbol, pattern_slot.
//   Load writes one pattern base; push shifts a stream byte into the 30-deep
//   window and checks all patterns in parallel; finish emits the results.
// Output channel (out_valid_o/out_ready_i) carries one transaction per
//   pattern, in pattern order, with last_o on the final one.
// Throughput: one input transaction per cycle. A finish drains PATTERNS
//   results at one per cycle while out_ready_i is high; a second finish waits
//   until that drain is done, while loads and pushes ahead of it keep flowing.
// An accepted transaction is held in the input register and executes from
//   there; the first result of a finish is valid the cycle after it executes.
// Reset clears the window, recorded matches and both channels; the pattern
//   store holds no reset value and must be loaded before a scan.
// A stalled receiver holds the current result; the input register then
//   backs up only for a further finish.
`default_nettype none

module dna_prefix_next_base_match
  import dpnbm_pkg::*;
#(
  parameter int unsigned PATTERNS    = PATTERNS_DEF,
  parameter int unsigned SLOT_STRIDE = SLOT_STRIDE_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] operation_i,
  input  wire logic [7:0] symbol_i,
  input  wire logic [8:0] pattern_slot_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      result_char_o,
  output logic [3:0]      pattern_index_o,
  output logic            last_o
);

  logic       ireg_v_q;
  logic [1:0] op_q;
  logic [7:0] sym_q;
  logic [8:0] slot_q;
  logic       fire;
  logic       emit_busy;
  logic       found [PATTERNS];
  logic [1:0] mbase [PATTERNS];

  assign fire       = ireg_v_q && (op_q != OP_FINISH || !emit_busy);
  assign in_ready_o = !ireg_v_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ireg_v_q <= 1'b0;
    end else if (in_ready_o) begin
      ireg_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q   <= operation_i;
      sym_q  <= symbol_i;
      slot_q <= pattern_slot_i;
    end
  end

  dpnbm_scan #(
    .PATTERNS   (PATTERNS),
    .SLOT_STRIDE(SLOT_STRIDE)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .op_i   (op_q),
    .sym_i  (sym_q),
    .slot_i (slot_q),
    .found_o(found),
    .base_o (mbase)
  );

  dpnbm_emit #(
    .PATTERNS(PATTERNS)
  ) u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (fire && op_q == OP_FINISH),
    .found_i        (found),
    .base_i         (mbase),
    .busy_o         (emit_busy),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_char_o  (result_char_o),
    .pattern_index_o(pattern_index_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire
